[design/tvet_pkg.sv]
// package for the target velocity tracker
// types and constants for the tracker module; no dependencies
package tvet_pkg;

	localparam int TARGET_COUNT_DEF = 16;
	localparam int POS_W = 24;
	localparam int TIME_W = 32;
	localparam int VEL_W = 16;
	localparam int SPEED_W = 15;
	localparam int WEIGHT_W = 9;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 8'd1;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 15'd7680;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd77;

	// one table row: last sample and smoothed velocity
	typedef struct packed {
		logic signed [POS_W-1:0] last_x;
		logic signed [POS_W-1:0] last_y;
		logic [TIME_W-1:0] last_time;
		logic signed [VEL_W-1:0] smooth_vx;
		logic signed [VEL_W-1:0] smooth_vy;
		logic vel_seen;
	} row_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_MUL,
		ST_DIVX,
		ST_DIVY,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_LIMX,
		ST_LIMY,
		ST_BLEND,
		ST_WRITE,
		ST_OUT
	} state_t;

endpackage

[design/target_velocity_ema_tracker.sv]
// top level of the target velocity tracker
// table memory, sequencer and shared divide / square root unit; uses tvet_pkg
//
// One report is taken at a time. Each report reads its target's row from a
// small synchronous table with a registered read, forms the raw velocity
// as position difference times 1000 over elapsed milliseconds with a
// bit-serial divider, limits its magnitude to max_speed using a bit-serial
// square root and two more divisions, blends it into the stored average and
// writes the row back. A report with a velocity always runs the two 64-step
// raw divides and then up to 4 normalization shifts. When the speed limit
// applies, a 31-step square root and two more 64-step divides follow.
// Row valid bits clear at reset, so no clearing pass is needed; an unwritten
// row reads as zero. The result sits in an output register, so the next
// report is taken once the previous result has been transferred. Ids at or
// above TARGET_COUNT return zero velocity and leave the table untouched.
module target_velocity_ema_tracker #(
	parameter int TARGET_COUNT = tvet_pkg::TARGET_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// report channel
	input  logic in_valid,
	output logic in_stall,
	input  logic [3:0] target_id,
	input  logic signed [tvet_pkg::POS_W-1:0] pos_x,
	input  logic signed [tvet_pkg::POS_W-1:0] pos_y,
	input  logic [tvet_pkg::TIME_W-1:0] time_ms,
	// result channel
	output logic out_valid,
	input  logic out_stall,
	output logic [3:0] result_id,
	output logic signed [tvet_pkg::VEL_W-1:0] vel_x,
	output logic signed [tvet_pkg::VEL_W-1:0] vel_y,
	output logic vel_valid,
	output logic speed_limited,
	// configuration write channel
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tvet_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tvet_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (TARGET_COUNT > 1) ? $clog2(TARGET_COUNT) : 1;

	tvet_pkg::state_t state_q, state_d;

	logic [tvet_pkg::SPEED_W-1:0] max_speed_q;
	logic [tvet_pkg::WEIGHT_W-1:0] weight_q;

	// table memory and its per-row valid bits
	tvet_pkg::row_t mem [TARGET_COUNT];
	tvet_pkg::row_t rd_q;
	logic [TARGET_COUNT-1:0] seen_q;
	logic seen_s1;
	logic mem_we;
	tvet_pkg::row_t wr_row;

	// captured report
	logic [3:0] id_q;
	logic [AW-1:0] addr_q;
	logic signed [tvet_pkg::POS_W-1:0] px_q, py_q;
	logic [tvet_pkg::TIME_W-1:0] t_q;
	logic in_range_q;

	// working registers
	logic neg_x_q, neg_y_q;
	logic [63:0] ax_q, ay_q;
	logic [32:0] dt_q;
	logic [61:0] sum_q;
	logic limited_q;
	logic signed [tvet_pkg::VEL_W-1:0] nvx_q, nvy_q;
	logic nvseen_q;

	// shared restoring divider: num / den, 64 steps
	logic [63:0] dnum_q, dquo_q;
	logic [63:0] drem_q;
	logic [63:0] dden_q;
	logic [6:0] cnt_q;
	logic [64:0] dtrial;

	// square root
	logic [61:0] srem_q;
	logic [30:0] sroot_q;
	logic [63:0] strial_rem;
	logic [63:0] strial_sub;
	logic sbit;
	logic [30:0] sroot_next;

	// squares, limit and limiter numerators
	logic [59:0] sqx, sqy;
	logic [29:0] lim2;
	logic [44:0] limx_num, limy_num;

	logic accept_in;
	logic rd_en;

	assign accept_in = in_valid && !in_stall;
	assign in_stall = (state_q != tvet_pkg::ST_IDLE) || out_valid;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= tvet_pkg::MAX_SPEED_RST;
			weight_q <= tvet_pkg::WEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tvet_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data[tvet_pkg::SPEED_W-1:0];
				tvet_pkg::REG_SMOOTHING: weight_q <= cfg_data[tvet_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// table memory: one write, one registered read
	assign rd_en = (state_q == tvet_pkg::ST_READ);
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			seen_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				seen_q[addr_q] <= 1'b1;
			end
			if (rd_en) begin
				seen_s1 <= seen_q[addr_q];
			end
		end
	end

	// row as seen this report: zero when never written
	tvet_pkg::row_t row;
	assign row = seen_s1 ? rd_q : '0;

	// divider and square root step logic
	assign dtrial = {drem_q, dnum_q[63]} - {1'b0, dden_q};
	assign strial_rem = {2'b00, srem_q};
	assign strial_sub = {31'd0, sroot_q, 2'b01} << (2 * cnt_q[4:0]);
	assign sbit = (strial_rem >= strial_sub);
	assign sroot_next = {sroot_q[29:0], sbit};

	assign sqx = {30'd0, ax_q[29:0]} * {30'd0, ax_q[29:0]};
	assign sqy = {30'd0, ay_q[29:0]} * {30'd0, ay_q[29:0]};
	assign lim2 = {15'd0, max_speed_q} * {15'd0, max_speed_q};
	assign limx_num = {15'd0, ax_q[29:0]} * {30'd0, max_speed_q};
	assign limy_num = {15'd0, ay_q[29:0]} * {30'd0, max_speed_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tvet_pkg::ST_IDLE:  if (accept_in) state_d = tvet_pkg::ST_READ;
			tvet_pkg::ST_READ:  state_d = tvet_pkg::ST_CHECK;
			tvet_pkg::ST_CHECK: begin
				if (!in_range_q) state_d = tvet_pkg::ST_OUT;
				else if (seen_s1 && t_q > row.last_time) state_d = tvet_pkg::ST_MUL;
				else state_d = tvet_pkg::ST_WRITE;
			end
			tvet_pkg::ST_MUL:   state_d = tvet_pkg::ST_DIVX;
			tvet_pkg::ST_DIVX:  if (cnt_q == 7'd0) state_d = tvet_pkg::ST_DIVY;
			tvet_pkg::ST_DIVY:  if (cnt_q == 7'd0) state_d = tvet_pkg::ST_NORM;
			tvet_pkg::ST_NORM:  begin
				if (ax_q[63:30] == '0 && ay_q[63:30] == '0) state_d = tvet_pkg::ST_SQ;
			end
			tvet_pkg::ST_SQ:    begin
				if (sum_q > {32'd0, lim2}) state_d = tvet_pkg::ST_SQRT;
				else state_d = tvet_pkg::ST_BLEND;
			end
			tvet_pkg::ST_SQRT:  if (cnt_q == 7'd0) state_d = tvet_pkg::ST_LIMX;
			tvet_pkg::ST_LIMX:  if (cnt_q == 7'd0) state_d = tvet_pkg::ST_LIMY;
			tvet_pkg::ST_LIMY:  if (cnt_q == 7'd0) state_d = tvet_pkg::ST_BLEND;
			tvet_pkg::ST_BLEND: state_d = tvet_pkg::ST_WRITE;
			tvet_pkg::ST_WRITE: state_d = tvet_pkg::ST_OUT;
			tvet_pkg::ST_OUT:   state_d = tvet_pkg::ST_IDLE;
			default:            state_d = tvet_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tvet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// blend helper values
	logic [8:0] w_eff;
	logic signed [10:0] w_s, wc_s;
	logic signed [31:0] rx_s, ry_s;
	logic signed [31:0] bx_new, bx_old, by_new, by_old;
	logic signed [43:0] bx, by;
	logic [43:0] bx_mag, by_mag;
	logic signed [tvet_pkg::VEL_W-1:0] bx_r, by_r;

	assign w_eff = (weight_q > 9'd256) ? 9'd256 : weight_q;
	assign w_s = $signed({2'b00, w_eff});
	assign wc_s = 11'sd256 - w_s;
	assign rx_s = neg_x_q ? -$signed({2'b00, ax_q[29:0]}) : $signed({2'b00, ax_q[29:0]});
	assign ry_s = neg_y_q ? -$signed({2'b00, ay_q[29:0]}) : $signed({2'b00, ay_q[29:0]});
	assign bx_new = 32'(w_s) * rx_s;
	assign bx_old = 32'(wc_s) * 32'(row.smooth_vx);
	assign by_new = 32'(w_s) * ry_s;
	assign by_old = 32'(wc_s) * 32'(row.smooth_vy);
	assign bx = 44'(bx_new) + 44'(bx_old);
	assign by = 44'(by_new) + 44'(by_old);
	assign bx_mag = bx[43] ? 44'(-bx) : 44'(bx);
	assign by_mag = by[43] ? 44'(-by) : 44'(by);
	assign bx_r = bx[43] ? -$signed(16'((bx_mag + 44'd128) >> 8))
		: $signed(16'((bx_mag + 44'd128) >> 8));
	assign by_r = by[43] ? -$signed(16'((by_mag + 44'd128) >> 8))
		: $signed(16'((by_mag + 44'd128) >> 8));

	// position differences
	logic signed [tvet_pkg::POS_W:0] dx, dy;
	assign dx = 25'(px_q) - 25'(row.last_x);
	assign dy = 25'(py_q) - 25'(row.last_y);

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			tvet_pkg::ST_IDLE: begin
				if (accept_in) begin
					id_q <= target_id;
					addr_q <= AW'(target_id);
					in_range_q <= ({28'd0, target_id} < 32'(TARGET_COUNT));
					px_q <= pos_x;
					py_q <= pos_y;
					t_q <= time_ms;
				end
			end
			tvet_pkg::ST_CHECK: begin
				limited_q <= 1'b0;
				nvx_q <= row.smooth_vx;
				nvy_q <= row.smooth_vy;
				nvseen_q <= row.vel_seen;
				neg_x_q <= dx[tvet_pkg::POS_W];
				neg_y_q <= dy[tvet_pkg::POS_W];
				ax_q <= 64'(dx[tvet_pkg::POS_W] ? -dx : dx);
				ay_q <= 64'(dy[tvet_pkg::POS_W] ? -dy : dy);
				dt_q <= 33'(t_q - row.last_time);
			end
			tvet_pkg::ST_MUL: begin
				// numerator = |dx| * 1000 + dt / 2
				dnum_q <= 64'(ax_q[24:0] * 35'd1000) + 64'(dt_q >> 1);
				ay_q <= 64'(ay_q[24:0] * 35'd1000) + 64'(dt_q >> 1);
				dden_q <= 64'(dt_q);
				drem_q <= '0;
				cnt_q <= 7'd63;
			end
			tvet_pkg::ST_DIVX, tvet_pkg::ST_DIVY, tvet_pkg::ST_LIMX, tvet_pkg::ST_LIMY: begin
				dquo_q <= {dquo_q[62:0], !dtrial[64]};
				if (cnt_q == 7'd0) begin
					drem_q <= '0;
					cnt_q <= 7'd63;
					unique case (state_q)
						tvet_pkg::ST_DIVX: begin
							ax_q <= {dquo_q[62:0], !dtrial[64]};
							dnum_q <= ay_q;
						end
						tvet_pkg::ST_DIVY: begin
							ay_q <= {dquo_q[62:0], !dtrial[64]};
						end
						tvet_pkg::ST_LIMX: begin
							ax_q <= {dquo_q[62:0], !dtrial[64]};
							dnum_q <= {19'd0, limy_num};
						end
						default: begin
							ay_q <= {dquo_q[62:0], !dtrial[64]};
						end
					endcase
				end else begin
					drem_q <= dtrial[64] ? {drem_q[62:0], dnum_q[63]} : dtrial[63:0];
					dnum_q <= {dnum_q[62:0], 1'b0};
					cnt_q <= cnt_q - 7'd1;
				end
			end
			tvet_pkg::ST_NORM: begin
				if (ax_q[63:30] != '0 || ay_q[63:30] != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else begin
					sum_q <= {2'b00, sqx} + {2'b00, sqy};
				end
			end
			tvet_pkg::ST_SQ: begin
				srem_q <= sum_q;
				sroot_q <= '0;
				cnt_q <= 7'd30;
				limited_q <= (sum_q > {32'd0, lim2});
			end
			tvet_pkg::ST_SQRT: begin
				// one result bit a step, from the top
				if (sbit) begin
					srem_q <= 62'(strial_rem - strial_sub);
				end
				sroot_q <= sroot_next;
				if (cnt_q == 7'd0) begin
					dden_q <= {33'd0, sroot_next};
					dnum_q <= {19'd0, limx_num};
					drem_q <= '0;
					cnt_q <= 7'd63;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
			tvet_pkg::ST_BLEND: begin
				nvseen_q <= 1'b1;
				if (row.vel_seen) begin
					nvx_q <= bx_r;
					nvy_q <= by_r;
				end else begin
					nvx_q <= 16'(rx_s);
					nvy_q <= 16'(ry_s);
				end
			end
			default: ;
		endcase
	end

	// write-back row
	assign mem_we = (state_q == tvet_pkg::ST_WRITE);
	always_comb begin
		wr_row.last_x = px_q;
		wr_row.last_y = py_q;
		wr_row.last_time = t_q;
		wr_row.smooth_vx = nvx_q;
		wr_row.smooth_vy = nvy_q;
		wr_row.vel_seen = nvseen_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == tvet_pkg::ST_OUT) begin
			out_valid <= 1'b1;
		end else if (out_valid && !out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tvet_pkg::ST_OUT) begin
			result_id <= id_q;
			vel_x <= in_range_q ? nvx_q : '0;
			vel_y <= in_range_q ? nvy_q : '0;
			vel_valid <= in_range_q && nvseen_q;
			speed_limited <= in_range_q && limited_q;
		end
	end

endmodule
